### rtl/core/clr_pkg.sv
// ============================================================================
// clr_pkg - shared types and constants for the clamped line rasterizer
// Operation codes, configuration register indexes, field widths.
// ============================================================================
`timescale 1ns / 1ps

package clr_pkg;

    // Default coordinate width; the top level can override it
    localparam int COORD_WIDTH_DEF = 10;

    // Fixed field widths
    localparam int IN_COORD_W  = 16;
    localparam int COLOR_W     = 16;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 4;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_WIDTH  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_HEIGHT = CFG_INDEX_W'(1);

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = CFG_DATA_W'(240);
    localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = CFG_DATA_W'(320);

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // Control for one item entering the line engine
    typedef struct packed
    {
        logic valid;
        op_t  op;
    } item_ctl_t;

endpackage

### rtl/core/clr_cfg.sv
// ============================================================================
// clr_cfg - display size registers
// Holds the largest legal column and row, derived from each size write.
// ============================================================================
`timescale 1ns / 1ps

module clr_cfg
    import clr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [COORD_WIDTH-1:0] x_max,
    output logic [COORD_WIDTH-1:0] y_max
);

    localparam int LIM_W = (CFG_DATA_W > COORD_WIDTH + 1) ? CFG_DATA_W : COORD_WIDTH + 1;

    // size 0 acts as 1, size above the coordinate span saturates to it
    function automatic logic [COORD_WIDTH-1:0] max_coord(input logic [CFG_DATA_W-1:0] size);
        logic [LIM_W-1:0] lim;
        logic [LIM_W-1:0] span;
        span = LIM_W'(1) << COORD_WIDTH;
        lim  = LIM_W'(size);
        if (lim == '0)
        begin
            lim = LIM_W'(1);
        end
        if (lim > span)
        begin
            lim = span;
        end
        return COORD_WIDTH'(lim - LIM_W'(1));
    endfunction

    localparam logic [COORD_WIDTH-1:0] X_MAX_RST = max_coord(WIDTH_RESET);
    localparam logic [COORD_WIDTH-1:0] Y_MAX_RST = max_coord(HEIGHT_RESET);

    logic [COORD_WIDTH-1:0] x_max_reg, x_max_next;
    logic [COORD_WIDTH-1:0] y_max_reg, y_max_next;

    always_comb
    begin
        x_max_next = x_max_reg;
        y_max_next = y_max_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_DISPLAY_WIDTH:  x_max_next = max_coord(cfg_data);
                REG_DISPLAY_HEIGHT: y_max_next = max_coord(cfg_data);
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_max_reg <= X_MAX_RST;
            y_max_reg <= Y_MAX_RST;
        end
        else
        begin
            x_max_reg <= x_max_next;
            y_max_reg <= y_max_next;
        end
    end

    assign x_max = x_max_reg;
    assign y_max = y_max_reg;

endmodule

### rtl/core/clr_engine.sv
// ============================================================================
// clr_engine - Bresenham line state and single-step update
// Clamps and sets up a line on load; emits and advances one pixel per tick.
// ============================================================================
`timescale 1ns / 1ps

module clr_engine
    import clr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  item_ctl_t              ctl,
    input  logic [IN_COORD_W-1:0]  start_x,
    input  logic [IN_COORD_W-1:0]  start_y,
    input  logic [IN_COORD_W-1:0]  end_x,
    input  logic [IN_COORD_W-1:0]  end_y,
    input  logic [COLOR_W-1:0]     color_in,
    input  logic [COORD_WIDTH-1:0] x_max,
    input  logic [COORD_WIDTH-1:0] y_max,
    output logic                   res_valid,
    output logic [COORD_WIDTH-1:0] res_x,
    output logic [COORD_WIDTH-1:0] res_y,
    output logic [COLOR_W-1:0]     res_color,
    output logic                   res_last,
    output logic                   line_active
);

    localparam int ERR_W = COORD_WIDTH + 2;

    function automatic logic [COORD_WIDTH-1:0] clamp(input logic [IN_COORD_W-1:0] v,
                                                     input logic [COORD_WIDTH-1:0] lim);
        if (v > IN_COORD_W'(lim))
        begin
            return lim;
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    logic [COORD_WIDTH-1:0]    cur_x_reg, cur_x_next;
    logic [COORD_WIDTH-1:0]    cur_y_reg, cur_y_next;
    logic [COORD_WIDTH-1:0]    tgt_x_reg, tgt_x_next;
    logic [COORD_WIDTH-1:0]    tgt_y_reg, tgt_y_next;
    logic [COORD_WIDTH-1:0]    dx_reg, dx_next;
    logic [COORD_WIDTH-1:0]    dy_reg, dy_next;
    logic                      x_neg_reg, x_neg_next;
    logic                      y_neg_reg, y_neg_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic [COLOR_W-1:0]        color_reg, color_next;
    logic                      active_reg, active_next;

    logic [COORD_WIDTH-1:0]    x0, y0, x1, y1;
    logic [COORD_WIDTH-1:0]    dx_load, dy_load;
    logic signed [ERR_W-1:0]   err_load;
    logic signed [ERR_W-1:0]   dx_s, dy_s;
    logic                      step_x, step_y, at_end;

    // load setup
    always_comb
    begin
        x0      = clamp(start_x, x_max);
        y0      = clamp(start_y, y_max);
        x1      = clamp(end_x, x_max);
        y1      = clamp(end_y, y_max);
        dx_load = (x0 < x1) ? (x1 - x0) : (x0 - x1);
        dy_load = (y0 < y1) ? (y1 - y0) : (y0 - y1);
        if (dx_load > dy_load)
        begin
            err_load = $signed({2'b00, dx_load >> 1});
        end
        else
        begin
            err_load = -$signed({2'b00, dy_load >> 1});
        end
    end

    // tick decisions, both taken against the error before the step
    assign dx_s   = $signed({2'b00, dx_reg});
    assign dy_s   = $signed({2'b00, dy_reg});
    assign step_x = err_reg > -dx_s;
    assign step_y = err_reg < dy_s;
    assign at_end = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);

    always_comb
    begin
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        tgt_x_next  = tgt_x_reg;
        tgt_y_next  = tgt_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        x_neg_next  = x_neg_reg;
        y_neg_next  = y_neg_reg;
        err_next    = err_reg;
        color_next  = color_reg;
        active_next = active_reg;
        if (ctl.valid)
        begin
            case (ctl.op)
                OP_LOAD:
                begin
                    cur_x_next  = x0;
                    cur_y_next  = y0;
                    tgt_x_next  = x1;
                    tgt_y_next  = y1;
                    dx_next     = dx_load;
                    dy_next     = dy_load;
                    x_neg_next  = !(x0 < x1);
                    y_neg_next  = !(y0 < y1);
                    err_next    = err_load;
                    color_next  = color_in;
                    active_next = 1'b1;
                end
                OP_TICK:
                begin
                    if (active_reg)
                    begin
                        if (at_end)
                        begin
                            active_next = 1'b0;
                        end
                        else
                        begin
                            err_next = err_reg - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);
                            if (step_x)
                            begin
                                cur_x_next = x_neg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
                            end
                            if (step_y)
                            begin
                                cur_y_next = y_neg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            tgt_x_reg  <= '0;
            tgt_y_reg  <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            x_neg_reg  <= 1'b0;
            y_neg_reg  <= 1'b0;
            err_reg    <= '0;
            color_reg  <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            tgt_x_reg  <= tgt_x_next;
            tgt_y_reg  <= tgt_y_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            x_neg_reg  <= x_neg_next;
            y_neg_reg  <= y_neg_next;
            err_reg    <= err_next;
            color_reg  <= color_next;
            active_reg <= active_next;
        end
    end

    assign res_valid   = ctl.valid && (ctl.op == OP_TICK) && active_reg;
    assign res_x       = cur_x_reg;
    assign res_y       = cur_y_reg;
    assign res_color   = color_reg;
    assign res_last    = at_end;
    assign line_active = active_reg;

endmodule

### rtl/core/clamped_line_rasterizer.sv
// ============================================================================
// clamped_line_rasterizer - clamped Bresenham line pixel generator
// Path: a tick is held in the input register, then its pixel in the output register.
// Throughput: one item per cycle while the output is not stalled; set by the single-step update in clr_engine.
// Reset: rst_n clears the line (idle) and both stages; sizes return to 240x320.
// ============================================================================
`timescale 1ns / 1ps

module clamped_line_rasterizer
    import clr_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    // item channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   op,
    input  logic [IN_COORD_W-1:0]  start_x,
    input  logic [IN_COORD_W-1:0]  start_y,
    input  logic [IN_COORD_W-1:0]  end_x,
    input  logic [IN_COORD_W-1:0]  end_y,
    input  logic [COLOR_W-1:0]     color_in,

    // pixel channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [COORD_WIDTH-1:0] pixel_x,
    output logic [COORD_WIDTH-1:0] pixel_y,
    output logic [COLOR_W-1:0]     pixel_color,
    output logic                   last_pixel
);

    // ------------------------------------------------------------------
    // Display size registers. Writes are always taken.
    // ------------------------------------------------------------------
    logic [COORD_WIDTH-1:0] x_max, y_max;

    assign cfg_ready = 1'b1;

    clr_cfg #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .x_max     (x_max),
        .y_max     (y_max)
    );

    // ------------------------------------------------------------------
    // Input register. The item sits here while the engine works on it;
    // it is held only when the output register is full and stalled,
    // so the engine's result has nowhere to go.
    // ------------------------------------------------------------------
    logic                  s1_valid_reg, s1_valid_next;
    op_t                   s1_op_reg;
    logic [IN_COORD_W-1:0] s1_sx_reg, s1_sy_reg, s1_ex_reg, s1_ey_reg;
    logic [COLOR_W-1:0]    s1_color_reg;
    logic                  in_xfer;
    logic                  advance;
    item_ctl_t             eng_ctl;
    logic                  out_valid_reg, out_valid_next;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_op_reg    <= op_t'(op);
            s1_sx_reg    <= start_x;
            s1_sy_reg    <= start_y;
            s1_ex_reg    <= end_x;
            s1_ey_reg    <= end_y;
            s1_color_reg <= color_in;
        end
    end

    assign eng_ctl.valid = advance;
    assign eng_ctl.op    = s1_op_reg;

    // ------------------------------------------------------------------
    // Line engine: load setup or one Bresenham step per advanced item.
    // ------------------------------------------------------------------
    logic                   res_valid, res_last, line_active;
    logic [COORD_WIDTH-1:0] res_x, res_y;
    logic [COLOR_W-1:0]     res_color;

    clr_engine #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (eng_ctl),
        .start_x     (s1_sx_reg),
        .start_y     (s1_sy_reg),
        .end_x       (s1_ex_reg),
        .end_y       (s1_ey_reg),
        .color_in    (s1_color_reg),
        .x_max       (x_max),
        .y_max       (y_max),
        .res_valid   (res_valid),
        .res_x       (res_x),
        .res_y       (res_y),
        .res_color   (res_color),
        .res_last    (res_last),
        .line_active (line_active)
    );

    // ------------------------------------------------------------------
    // Output register. Refilled on every advance (a load or an idle tick
    // leaves it empty); otherwise it drains on a transfer.
    // ------------------------------------------------------------------
    logic [COORD_WIDTH-1:0] out_x_reg, out_y_reg;
    logic [COLOR_W-1:0]     out_color_reg;
    logic                   out_last_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = res_valid;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_x_reg     <= res_x;
            out_y_reg     <= res_y;
            out_color_reg <= res_color;
            out_last_reg  <= res_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = out_x_reg;
    assign pixel_y     = out_y_reg;
    assign pixel_color = out_color_reg;
    assign last_pixel  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // input only backs up behind a full, stalled output register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without downstream backpressure");

    // emitting the end point retires the line
    a_last_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && res_valid && res_last) |=> !line_active)
        else $error("line still active after its last pixel");

    // a tick on an idle line leaves nothing in the output register
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (s1_op_reg == OP_TICK) && !line_active) |=> !out_valid)
        else $error("idle tick produced a pixel");

    // a load never produces a pixel but always starts a line
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (s1_op_reg == OP_LOAD)) |=> (line_active && !out_valid))
        else $error("load did not start a line cleanly");

endmodule
